@@ rtl/ium_pkg.sv @@
package ium_pkg;

    // store geometry
    localparam int MAX_RANGES = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int VAL_W      = 24;
    localparam int SPAN_W     = 2 * VAL_W;

    // fixed point value, 8 fraction bits
    typedef logic signed [VAL_W-1:0] t_val;

    // one stored closed range
    typedef struct packed {
        logic signed [VAL_W-1:0] low;
        logic signed [VAL_W-1:0] high;
    } t_span;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;

endpackage

@@ rtl/ium_if.sv @@
// range input channel
interface ium_rng_if import ium_pkg::*; ();
    logic valid;
    logic ready;
    t_val range_low;
    t_val range_high;
    logic last_in;

    modport source (output valid, output range_low, output range_high, output last_in,
                    input ready);
    modport sink   (input valid, input range_low, input range_high, input last_in,
                    output ready);
endinterface

// merged range output channel
interface ium_mrg_if import ium_pkg::*; ();
    logic valid;
    logic ready;
    t_val merged_low;
    t_val merged_high;
    logic last_out;
    logic overflowed;

    modport source (output valid, output merged_low, output merged_high,
                    output last_out, output overflowed, input ready);
    modport sink   (input valid, input merged_low, input merged_high,
                    input last_out, input overflowed, output ready);
endinterface

@@ rtl/ium_ram.sv @@
module ium_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/interval_union_merger_unit.sv @@
// interval union merger
// input channel i_rng: one closed range word per transfer (range_low,
// range_high, signed fixed point with 8 fraction bits), last_in marks the
// final range of a set. loading takes one cycle per word; ready is high
// only while the block is loading. ranges beyond MAX_RANGES are dropped
// and the run's overflowed flag is set.
// after the last word the block merges the stored set in place with a
// single comparator and a range RAM with one write and one registered
// read port. each outer slot is read and held, every later slot is read
// and compared with it; each merge grows the held range and moves the
// final entry into the removed slot. passes repeat until one leaves the
// set unchanged.
// output channel o_mrg: the merged ranges in store order, each read only
// after the previous one is taken, last_out on the final one and
// overflowed the same on all of them. a stalled receiver simply holds the
// block in its output phase; the word stays registered and stable.
// when the final word is taken the store is emptied and loading resumes.
// reset (i_rst_n low, synchronous) empties the store and clears the flag;
// RAM contents are not cleared, only slots written in a run are read.
module interval_union_merger_unit import ium_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ium_rng_if.sink   i_rng,
    ium_mrg_if.source o_mrg
);

    // sequencer codes
    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_RD_A    = 4'd1;
    localparam logic [3:0] S_LD_A    = 4'd2;
    localparam logic [3:0] S_RD_B    = 4'd3;
    localparam logic [3:0] S_CMP     = 4'd4;
    localparam logic [3:0] S_MOVE    = 4'd5;
    localparam logic [3:0] S_OUT_RD  = 4'd6;
    localparam logic [3:0] S_OUT_LD  = 4'd7;
    localparam logic [3:0] S_OUT_HLD = 4'd8;

    localparam t_cnt CNT_ONE = t_cnt'(1);
    localparam t_cnt CNT_MAX = t_cnt'(MAX_RANGES);

    logic [3:0] r_state, n_state;
    t_cnt       r_cnt, n_cnt;
    t_cnt       r_a, n_a;
    t_cnt       r_b, n_b;
    t_cnt       r_k, n_k;
    logic       r_ovf, n_ovf;
    logic       r_chg, n_chg;
    t_span      r_span_a, n_span_a;

    // output word register
    logic       r_out_vld, n_out_vld;
    t_val       r_out_low, n_out_low;
    t_val       r_out_high, n_out_high;
    logic       r_out_last, n_out_last;
    logic       r_out_ovf, n_out_ovf;

    // ram port
    logic             ram_we;
    t_idx             ram_waddr;
    logic [SPAN_W-1:0] ram_wdata;
    t_idx             ram_raddr;
    logic [SPAN_W-1:0] ram_rdata;
    t_span            rd_span;

    logic  in_acc;
    logic  out_acc;
    logic  overlap;
    t_cnt  cnt_m1;

    ium_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (MAX_RANGES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_span = t_span'(ram_rdata);
    assign in_acc  = i_rng.valid && i_rng.ready;
    assign out_acc = o_mrg.valid && o_mrg.ready;
    assign cnt_m1  = r_cnt - CNT_ONE;

    // shared comparator: later slot touches or overlaps held range
    assign overlap = (rd_span.low <= r_span_a.high) && (rd_span.high >= r_span_a.low);

    // handshake and payload
    assign i_rng.ready       = (r_state == S_LOAD);
    assign o_mrg.valid       = r_out_vld;
    assign o_mrg.merged_low  = r_out_low;
    assign o_mrg.merged_high = r_out_high;
    assign o_mrg.last_out    = r_out_last;
    assign o_mrg.overflowed  = r_out_ovf;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_a        = r_a;
        n_b        = r_b;
        n_k        = r_k;
        n_ovf      = r_ovf;
        n_chg      = r_chg;
        n_span_a   = r_span_a;
        n_out_vld  = r_out_vld;
        n_out_low  = r_out_low;
        n_out_high = r_out_high;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt[IDX_W-1:0];
        ram_wdata  = {i_rng.range_low, i_rng.range_high};
        ram_raddr  = r_a[IDX_W-1:0];

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_cnt < CNT_MAX) begin
                        ram_we = 1'b1;
                        n_cnt  = r_cnt + CNT_ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_rng.last_in) begin
                        n_a     = '0;
                        n_chg   = 1'b0;
                        n_state = S_RD_A;
                    end
                end
            end
            S_RD_A: begin
                ram_raddr = r_a[IDX_W-1:0];
                n_state   = S_LD_A;
            end
            S_LD_A: begin
                n_span_a = rd_span;
                n_b      = r_a + CNT_ONE;
                n_state  = S_RD_B;
            end
            S_RD_B: begin
                if (r_b >= r_cnt) begin
                    // outer slot done: put the grown range back
                    ram_we    = 1'b1;
                    ram_waddr = r_a[IDX_W-1:0];
                    ram_wdata = r_span_a;
                    if ((r_a + CNT_ONE) >= r_cnt) begin
                        if (r_chg) begin
                            n_a     = '0;
                            n_chg   = 1'b0;
                            n_state = S_RD_A;
                        end else begin
                            n_k     = '0;
                            n_state = S_OUT_RD;
                        end
                    end else begin
                        n_a     = r_a + CNT_ONE;
                        n_state = S_RD_A;
                    end
                end else begin
                    ram_raddr = r_b[IDX_W-1:0];
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (overlap) begin
                    if (rd_span.low < r_span_a.low) begin
                        n_span_a.low = rd_span.low;
                    end
                    if (rd_span.high > r_span_a.high) begin
                        n_span_a.high = rd_span.high;
                    end
                    ram_raddr = cnt_m1[IDX_W-1:0];
                    n_chg     = 1'b1;
                    n_state   = S_MOVE;
                end else begin
                    n_b     = r_b + CNT_ONE;
                    n_state = S_RD_B;
                end
            end
            S_MOVE: begin
                // final entry fills the removed slot
                ram_we    = 1'b1;
                ram_waddr = r_b[IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_cnt     = cnt_m1;
                n_state   = S_RD_B;
            end
            S_OUT_RD: begin
                ram_raddr = r_k[IDX_W-1:0];
                n_state   = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_out_vld  = 1'b1;
                n_out_low  = rd_span.low;
                n_out_high = rd_span.high;
                n_out_last = ((r_k + CNT_ONE) == r_cnt);
                n_out_ovf  = r_ovf;
                n_state    = S_OUT_HLD;
            end
            S_OUT_HLD: begin
                if (out_acc) begin
                    n_out_vld = 1'b0;
                    if (r_out_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + CNT_ONE;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_chg     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ovf     <= n_ovf;
            r_chg     <= n_chg;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_k        <= n_k;
        r_span_a   <= n_span_a;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    // store never holds more than its capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("range count beyond capacity");

    // no input taken while a merged word is pending
    a_no_overlap_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rng.ready |-> !o_mrg.valid)
        else $error("input ready during output phase");

    // taking the final word empties the store and clears the flag
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_mrg.last_out) |=> (r_cnt == '0 && !r_ovf && i_rng.ready))
        else $error("store not emptied after run");

    // a compared slot always lies inside the live set
    a_cmp_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_b < r_cnt && r_a < r_b))
        else $error("compare slot outside live set");

endmodule

@@ dv/tb_interval_union_merger_unit.sv @@
module tb_interval_union_merger_unit import ium_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VMIN        = -8388608;
    localparam int VMAX        = 8388607;
    localparam int WORDS_TOTAL = 460;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 60;
    localparam int IDLE_PCT    = 17;

    // one merged range word as it leaves the block
    typedef struct {
        t_val low;
        t_val high;
        logic last;
        logic ovf;
    } t_merged_word;

    // one directed stimulus row; typed rows carry their own expectation
    typedef struct {
        int lo;
        int hi;
        bit last;
        bit typed;
        int exp_lo;
        int exp_hi;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    ium_rng_if rng_bus ();
    ium_mrg_if mrg_bus ();

    interval_union_merger_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rng   (rng_bus),
        .o_mrg   (mrg_bus)
    );

    // ranges held by the predictor for the current set
    t_val held_low [MAX_RANGES];
    t_val held_high[MAX_RANGES];
    int   held_count;
    logic held_dropped;

    t_merged_word merged_due[$];
    int mismatch_count;
    int words_sent;
    int cycle_count;
    logic calm;

    // stretch with no idling on either side
    assign calm = (words_sent >= 180) && (words_sent < 290);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // predictor: store one range, on the last word merge and queue the set
    function automatic void load_range(input t_val lo, input t_val hi, input logic lst);
        bit changed;
        int a;
        int b;
        t_merged_word w;
        if (held_count < MAX_RANGES) begin
            held_low[held_count]  = lo;
            held_high[held_count] = hi;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!lst) return;
        // repeat merge passes until one changes nothing
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (a = 0; a < held_count; a++) begin
                b = a + 1;
                while (b < held_count) begin
                    if (held_low[b] <= held_high[a] && held_high[b] >= held_low[a]) begin
                        if (held_low[b] < held_low[a]) held_low[a] = held_low[b];
                        if (held_high[b] > held_high[a]) held_high[a] = held_high[b];
                        held_low[b]  = held_low[held_count-1];
                        held_high[b] = held_high[held_count-1];
                        held_count--;
                        changed = 1'b1;
                    end else begin
                        b++;
                    end
                end
            end
        end
        // emit survivors in store order
        for (a = 0; a < held_count; a++) begin
            w.low  = held_low[a];
            w.high = held_high[a];
            w.last = (a == held_count - 1);
            w.ovf  = held_dropped;
            merged_due.insert(merged_due.size(), w);
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // drive one range word at the falling edge, return once it is taken
    task automatic send_word(input t_val lo, input t_val hi, input logic lst);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            rng_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        rng_bus.valid      <= 1'b1;
        rng_bus.range_low  <= lo;
        rng_bus.range_high <= hi;
        rng_bus.last_in    <= lst;
        do @(posedge i_clk); while (!rng_bus.ready);
        words_sent++;
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        mrg_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // compare each taken merged word with the oldest expectation
    always @(posedge i_clk) begin
        t_merged_word want;
        if (i_rst_n && mrg_bus.valid && mrg_bus.ready) begin
            if (merged_due.size() == 0) begin
                note_mismatch($sformatf("unexpected word low %0d high %0d",
                                        mrg_bus.merged_low, mrg_bus.merged_high));
            end else begin
                want = merged_due.pop_front();
                if (mrg_bus.merged_low !== want.low)
                    note_mismatch($sformatf("merged_low got %0d want %0d",
                                            mrg_bus.merged_low, want.low));
                if (mrg_bus.merged_high !== want.high)
                    note_mismatch($sformatf("merged_high got %0d want %0d",
                                            mrg_bus.merged_high, want.high));
                if (mrg_bus.last_out !== want.last)
                    note_mismatch($sformatf("last_out got %b want %b",
                                            mrg_bus.last_out, want.last));
                if (mrg_bus.overflowed !== want.ovf)
                    note_mismatch($sformatf("overflowed got %b want %b",
                                            mrg_bus.overflowed, want.ovf));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_plan_row plan[20];
        int set_idx;
        int set_len;
        int k;
        int r;
        int set_base;
        int prev_hi;
        int lo_i;
        int hi_i;
        int tmp;
        t_val lo;
        t_val hi;

        held_count     = 0;
        held_dropped   = 1'b0;
        mismatch_count = 0;
        words_sent     = 0;
        cycle_count    = 0;

        i_rst_n            = 1'b0;
        rng_bus.valid      = 1'b0;
        rng_bus.range_low  = '0;
        rng_bus.range_high = '0;
        rng_bus.last_in    = 1'b0;
        mrg_bus.ready      = 1'b0;

        plan = '{
            // single range sets: the word comes back as it went in
            '{VMIN, VMAX, 1'b1, 1'b1, VMIN, VMAX},
            '{VMAX, VMAX, 1'b1, 1'b1, VMAX, VMAX},
            '{VMIN, VMIN, 1'b1, 1'b1, VMIN, VMIN},
            '{VMAX, VMIN, 1'b1, 1'b1, VMAX, VMIN},
            '{-1,   -1,   1'b1, 1'b1, -1,   -1},
            // touching ends merge, the far one stays
            '{0,    256,  1'b0, 1'b0, 0, 0},
            '{256,  512,  1'b0, 1'b0, 0, 0},
            '{1024, 2048, 1'b1, 1'b0, 0, 0},
            // bridge range only joins the outer two on a second pass
            '{0,    10,   1'b0, 1'b0, 0, 0},
            '{20,   30,   1'b0, 1'b0, 0, 0},
            '{5,    25,   1'b1, 1'b0, 0, 0},
            // inverted range compared as given
            '{100,  50,   1'b0, 1'b0, 0, 0},
            '{40,   60,   1'b0, 1'b0, 0, 0},
            '{70,   80,   1'b1, 1'b0, 0, 0},
            // full span built from both extremes
            '{VMIN, 0,    1'b0, 1'b0, 0, 0},
            '{0,    VMAX, 1'b0, 1'b0, 0, 0},
            '{-5,   5,    1'b1, 1'b0, 0, 0},
            // one lsb apart does not merge
            '{500,  600,  1'b0, 1'b0, 0, 0},
            '{700,  800,  1'b0, 1'b0, 0, 0},
            '{601,  699,  1'b1, 1'b0, 0, 0}
        };

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (plan[i]) begin
            send_word(t_val'(plan[i].lo), t_val'(plan[i].hi), plan[i].last);
            load_range(t_val'(plan[i].lo), t_val'(plan[i].hi), plan[i].last);
            if (plan[i].typed) begin
                merged_due[merged_due.size()-1].low  = t_val'(plan[i].exp_lo);
                merged_due[merged_due.size()-1].high = t_val'(plan[i].exp_hi);
                merged_due[merged_due.size()-1].last = 1'b1;
                merged_due[merged_due.size()-1].ovf  = 1'b0;
            end
        end

        // random sets, a few sized to fill or overrun the store
        set_idx = 0;
        while (words_sent < WORDS_TOTAL) begin
            r = $urandom_range(0, 99);
            if (set_idx == 3)       set_len = MAX_RANGES + 2;
            else if (set_idx == 10) set_len = MAX_RANGES;
            else if (set_idx == 17) set_len = MAX_RANGES + 1;
            else if (set_idx == 40) set_len = MAX_RANGES + 5;
            else if (r < 70)        set_len = $urandom_range(1, 6);
            else if (r < 92)        set_len = $urandom_range(7, 16);
            else                    set_len = $urandom_range(17, MAX_RANGES - 1);
            set_base = int'($urandom_range(0, 16000000)) - 8000000;
            prev_hi  = set_base;
            for (k = 0; k < set_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    // anything at all
                    lo = t_val'($urandom);
                    hi = t_val'($urandom);
                end else if (r < 14) begin
                    lo = $urandom_range(0, 1) ? t_val'(VMIN) : t_val'(VMAX);
                    hi = $urandom_range(0, 1) ? t_val'(VMIN) : t_val'(VMAX);
                end else begin
                    // clustered around the set base so that ranges meet
                    lo_i = set_base + int'($urandom_range(0, 6000)) - 3000;
                    if (r < 24) lo_i = prev_hi;
                    hi_i = lo_i + int'($urandom_range(0, 1200));
                    prev_hi = hi_i;
                    if (r < 32) begin
                        tmp  = lo_i;
                        lo_i = hi_i;
                        hi_i = tmp;
                    end
                    lo = t_val'(lo_i);
                    hi = t_val'(hi_i);
                end
                send_word(lo, hi, k == set_len - 1);
                load_range(lo, hi, k == set_len - 1);
            end
            set_idx++;
        end

        @(negedge i_clk);
        rng_bus.valid   <= 1'b0;
        rng_bus.last_in <= 1'b0;

        // drain, then give stray words a chance to show up
        while (merged_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
